// ===== rtl/hsps_pkg.sv =====
// Shared types, parse phase codes and field length table for the SPS parser.
// No dependencies; imported by every RTL module of the block.
package hsps_pkg;

  localparam int MIN_SET_BYTES_DEF   = 20;
  localparam int MAX_GOLOMB_BITS_DEF = 32;
  localparam int QUEUE_DEPTH         = 4;
  localparam int QUEUE_AW            = $clog2(QUEUE_DEPTH);

  localparam int OUT_TDATA_W = 80;

  typedef enum logic [4:0] {
    PH_VPS       = 5'd0,
    PH_MAXSUB    = 5'd1,
    PH_NEST      = 5'd2,
    PH_PTLA      = 5'd3,
    PH_PROFILE   = 5'd4,
    PH_SKIP32    = 5'd5,
    PH_SKIP48    = 5'd6,
    PH_LEVEL     = 5'd7,
    PH_SLFLAGS   = 5'd8,
    PH_RESERVED  = 5'd9,
    PH_SL_ENTRY  = 5'd10,
    PH_SLPROF_A  = 5'd11,
    PH_SLPROF_B  = 5'd12,
    PH_SL_LVLCHK = 5'd13,
    PH_SLLEVEL   = 5'd14,
    PH_SPSID     = 5'd15,
    PH_CHROMA    = 5'd16,
    PH_SEPCOL    = 5'd17,
    PH_WIDTH     = 5'd18,
    PH_HEIGHT    = 5'd19,
    PH_CONFFLAG  = 5'd20,
    PH_CONF      = 5'd21,
    PH_DEPTHL    = 5'd22,
    PH_DEPTHC    = 5'd23,
    PH_POC       = 5'd24,
    PH_ORDFLAG   = 5'd25,
    PH_ORD0      = 5'd26,
    PH_ORD1      = 5'd27,
    PH_ORD2      = 5'd28,
    PH_MINCB     = 5'd29,
    PH_DIFF      = 5'd30,
    PH_DONE      = 5'd31
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_SUBLAYERS = 3'd2,
    ST_ID        = 3'd3,
    ST_CHROMA    = 3'd4,
    ST_DEPTH     = 3'd5,
    ST_TRUNC     = 3'd6,
    ST_RANGE     = 3'd7
  } status_t;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } byte_item_t;

  // Fixed field widths in bits; zero marks an Exp-Golomb field, a loop decision or the reserved bits.
  function automatic logic [5:0] field_len(input phase_t ph);
    logic [5:0] len;
    case (ph)
      PH_VPS:      len = 6'd4;
      PH_MAXSUB:   len = 6'd3;
      PH_NEST:     len = 6'd1;
      PH_PTLA:     len = 6'd3;
      PH_PROFILE:  len = 6'd5;
      PH_SKIP32:   len = 6'd32;
      PH_SKIP48:   len = 6'd48;
      PH_LEVEL:    len = 6'd8;
      PH_SLFLAGS:  len = 6'd2;
      PH_SLPROF_A: len = 6'd40;
      PH_SLPROF_B: len = 6'd48;
      PH_SLLEVEL:  len = 6'd8;
      PH_SEPCOL:   len = 6'd1;
      PH_CONFFLAG: len = 6'd1;
      PH_ORDFLAG:  len = 6'd1;
      default:     len = 6'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/hevc_sps_field_parser_core.sv =====
// Top level of the HEVC sequence parameter set field parser.
// Depends on hsps_pkg, hsps_byte_fifo and hsps_bit_parser.
//
// Usage:
//   Feed the SPS payload (emulation-prevention bytes removed) one byte per
//   item on the in_ channel; in_tlast marks the final byte of the set.
//   On that byte the block emits one item on the out_ channel with the
//   status and, if OK, the decoded picture fields; other bytes give no result.
// Throughput: the back end shifts one bit per cycle while it holds a byte;
//   it pauses at each sub-layer loop decision and while a result is built.
//   The four-entry byte queue lets the source run ahead of the bit shifter.
// Result path: after the last bit of the final byte, S_CTB registers the status
//   and CTB counts, then S_MUL puts the 17x17 multiply into the output register.
// Reset: rst_n low empties the queue and returns the parser to the first
//   header field; no clearing pass is needed.
// Stall: while out_tready is low the result holds; parsing of the next set
//   continues and only stops before its own result would be written.
module hevc_sps_field_parser_core
  import hsps_pkg::*;
#(
  parameter int MIN_SET_BYTES   = MIN_SET_BYTES_DEF,
  parameter int MAX_GOLOMB_BITS = MAX_GOLOMB_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // last_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] status, [7:3] profile_idc, [15:8] level_idc, [31:16] pic_width,
  // [47:32] pic_height, [74:48] pic_size_in_ctbs, [79:75] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic       q_full, q_valid, q_pop;
  byte_item_t q_in, q_head;

  assign q_in.data = in_tdata;
  assign q_in.last = in_tlast;
  assign in_tready = !q_full;

  hsps_byte_fifo u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid && !q_full),
    .push_item  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  hsps_bit_parser #(
    .MIN_SET_BYTES   (MIN_SET_BYTES),
    .MAX_GOLOMB_BITS (MAX_GOLOMB_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_item  (q_head),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

endmodule

// ===== rtl/hsps_byte_fifo.sv =====
// Front part: accepts payload bytes into a short show-ahead queue.
// Depends on hsps_pkg for the queue depth and the byte item type.
module hsps_byte_fifo
  import hsps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  byte_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output byte_item_t head_item
);

  byte_item_t           mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]    count_r;

  assign full       = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/hsps_bit_parser.sv =====
// Back part: bit-serial parse of queued bytes, result build and output register.
// Depends on hsps_pkg for phase codes, status codes and the field length table.
module hsps_bit_parser
  import hsps_pkg::*;
#(
  parameter int MIN_SET_BYTES   = MIN_SET_BYTES_DEF,
  parameter int MAX_GOLOMB_BITS = MAX_GOLOMB_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  byte_item_t             head_item,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int BCW = $clog2(MIN_SET_BYTES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_BITS = 4'b0010,
    S_CTB  = 4'b0100,
    S_MUL  = 4'b1000
  } ctl_t;

  ctl_t            st_r, st_nxt;
  phase_t          phase_r, phase_nxt;
  logic [5:0]      fbc_r, fbc_nxt;
  logic [2:0]      slc_r, slc_nxt;
  logic [3:0]      li_r, li_nxt;
  logic [11:0]     flags_r, flags_nxt;
  logic [5:0]      zc_r, zc_nxt;
  logic [32:0]     acc_r, acc_nxt;
  logic [31:0]     luma_r, luma_nxt;
  logic [5:0]      mbl_r, mbl_nxt;
  logic [4:0]      prof_r, prof_nxt;
  logic [7:0]      lvl_r, lvl_nxt;
  logic [15:0]     w_r, w_nxt;
  logic [15:0]     h_r, h_nxt;
  logic [2:0]      err_r, err_nxt;
  logic [BCW-1:0]  bcnt_r, bcnt_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic [2:0]      bidx_r, bidx_nxt;
  logic            last_r, last_nxt;
  logic [16:0]     wc_r, wc_nxt, hc_r, hc_nxt;
  logic [2:0]      stat_r, stat_nxt;
  logic            ov_r, ov_nxt;
  logic [OUT_TDATA_W-1:0] od_r, od_nxt;

  logic        b, load, go_en, fin_en, out_free;
  phase_t      go_ph;
  logic [32:0] v;
  logic [33:0] t;
  logic [16:0] ctb_m1;
  logic [33:0] prod;

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign out_free  = !ov_r || out_ready;
  assign pop       = load;
  assign b         = byte_r[bidx_r];
  assign ctb_m1    = (17'd1 << mbl_r[2:0]) - 17'd1;
  assign prod      = wc_r * hc_r;

  always_comb begin
    st_nxt = st_r; phase_nxt = phase_r; fbc_nxt = fbc_r; slc_nxt = slc_r;
    li_nxt = li_r; flags_nxt = flags_r; zc_nxt = zc_r; acc_nxt = acc_r;
    luma_nxt = luma_r; mbl_nxt = mbl_r; prof_nxt = prof_r; lvl_nxt = lvl_r;
    w_nxt = w_r; h_nxt = h_r; err_nxt = err_r; bcnt_nxt = bcnt_r;
    byte_nxt = byte_r; bidx_nxt = bidx_r; last_nxt = last_r;
    wc_nxt = wc_r; hc_nxt = hc_r; stat_nxt = stat_r;
    ov_nxt = ov_r && !out_ready; od_nxt = od_r;
    load = 1'b0; go_en = 1'b0; go_ph = PH_DONE; fin_en = 1'b0; v = '0;
    t = '0;

    case (st_r)
      S_IDLE: begin
        if (head_valid) load = 1'b1;
      end
      S_BITS: begin
        if (phase_r == PH_SL_ENTRY) begin
          // resolve the sub-layer loop head without taking a bit
          go_en = 1'b1;
          if (li_r >= {1'b0, slc_r} || li_r > 4'd5) go_ph = PH_SPSID;
          else if (flags_r[{li_r[2:0], 1'b0}]) go_ph = PH_SLPROF_A;
          else go_ph = PH_SL_LVLCHK;
        end else if (phase_r == PH_SL_LVLCHK) begin
          go_en = 1'b1;
          if (flags_r[{li_r[2:0], 1'b1}]) go_ph = PH_SLLEVEL;
          else begin
            li_nxt = li_r + 4'd1;
            go_ph  = PH_SL_ENTRY;
          end
        end else begin
          if (phase_r != PH_DONE) begin
            if (field_len(phase_r) == 6'd0 && phase_r != PH_RESERVED) begin
              if (acc_r == '0) begin
                if (!b) begin
                  zc_nxt = zc_r + 6'd1;
                  if (zc_nxt >= 6'(MAX_GOLOMB_BITS)) begin
                    err_nxt = ST_RANGE; phase_nxt = PH_DONE;
                  end
                end else if (zc_r == '0) begin
                  fin_en = 1'b1; v = '0;
                end else begin
                  acc_nxt = 33'd1;
                  fbc_nxt = zc_r;
                end
              end else begin
                acc_nxt = {acc_r[31:0], b};
                fbc_nxt = fbc_r - 6'd1;
                if (fbc_nxt == '0) begin
                  fin_en = 1'b1; v = acc_nxt - 33'd1;
                end
              end
            end else begin
              acc_nxt = {acc_r[31:0], b};
              if (fbc_r != '0) fbc_nxt = fbc_r - 6'd1;
              if (fbc_nxt == '0) begin
                fin_en = 1'b1; v = acc_nxt;
              end
            end
          end
          bidx_nxt = bidx_r - 3'd1;
          if (bidx_r == 3'd0) begin
            if (last_r) st_nxt = S_CTB;
            else if (head_valid) load = 1'b1;
            else st_nxt = S_IDLE;
          end
        end
      end
      S_CTB: begin
        if (bcnt_r < BCW'(MIN_SET_BYTES)) stat_nxt = ST_SHORT;
        else if (err_r != '0) stat_nxt = err_r;
        else if (phase_r != PH_DONE) stat_nxt = ST_TRUNC;
        else stat_nxt = ST_OK;
        wc_nxt = ({1'b0, w_r} + ctb_m1) >> mbl_r[2:0];
        hc_nxt = ({1'b0, h_r} + ctb_m1) >> mbl_r[2:0];
        st_nxt = S_MUL;
      end
      S_MUL: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = '0;
          od_nxt[2:0] = stat_r;
          if (stat_r == ST_OK) begin
            od_nxt[7:3]   = prof_r;
            od_nxt[15:8]  = lvl_r;
            od_nxt[31:16] = w_r;
            od_nxt[47:32] = h_r;
            od_nxt[74:48] = prod[26:0];
          end
          // return to the reset state for the next parameter set
          phase_nxt = PH_VPS; fbc_nxt = field_len(PH_VPS); slc_nxt = '0;
          li_nxt = '0; flags_nxt = '0; zc_nxt = '0; acc_nxt = '0; luma_nxt = '0;
          mbl_nxt = '0; prof_nxt = '0; lvl_nxt = '0; w_nxt = '0; h_nxt = '0;
          err_nxt = '0; bcnt_nxt = '0;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (fin_en) begin
      case (phase_r)
        PH_MAXSUB: begin
          slc_nxt = v[2:0];
          if (v[2:0] > 3'd6) begin
            err_nxt = ST_SUBLAYERS; phase_nxt = PH_DONE;
          end else begin
            go_en = 1'b1; go_ph = PH_NEST;
          end
        end
        PH_PROFILE: begin
          prof_nxt = v[4:0]; go_en = 1'b1; go_ph = PH_SKIP32;
        end
        PH_LEVEL: begin
          lvl_nxt = v[7:0]; li_nxt = '0; go_en = 1'b1;
          go_ph = (slc_r != '0) ? PH_SLFLAGS : PH_SPSID;
        end
        PH_SLFLAGS: begin
          if (li_r < 4'd6) begin
            flags_nxt[{li_r[2:0], 1'b0}] = v[1];
            flags_nxt[{li_r[2:0], 1'b1}] = v[0];
          end
          li_nxt = li_r + 4'd1; go_en = 1'b1;
          go_ph = (li_nxt < {1'b0, slc_r}) ? PH_SLFLAGS : PH_RESERVED;
        end
        PH_RESERVED: begin
          li_nxt = '0; go_en = 1'b1; go_ph = PH_SL_ENTRY;
        end
        PH_SLLEVEL: begin
          li_nxt = li_r + 4'd1; go_en = 1'b1; go_ph = PH_SL_ENTRY;
        end
        PH_SPSID: begin
          if (v > 33'd15) begin
            err_nxt = ST_ID; phase_nxt = PH_DONE;
          end else begin
            go_en = 1'b1; go_ph = PH_CHROMA;
          end
        end
        PH_CHROMA: begin
          if (v > 33'd3) begin
            err_nxt = ST_CHROMA; phase_nxt = PH_DONE;
          end else begin
            go_en = 1'b1; go_ph = (v == 33'd3) ? PH_SEPCOL : PH_WIDTH;
          end
        end
        PH_WIDTH: begin
          if (v > 33'd65535) begin
            err_nxt = ST_RANGE; phase_nxt = PH_DONE;
          end else begin
            w_nxt = v[15:0]; go_en = 1'b1; go_ph = PH_HEIGHT;
          end
        end
        PH_HEIGHT: begin
          if (v > 33'd65535) begin
            err_nxt = ST_RANGE; phase_nxt = PH_DONE;
          end else begin
            h_nxt = v[15:0]; go_en = 1'b1; go_ph = PH_CONFFLAG;
          end
        end
        PH_CONFFLAG: begin
          li_nxt = '0; go_en = 1'b1; go_ph = (v != '0) ? PH_CONF : PH_DEPTHL;
        end
        PH_CONF: begin
          li_nxt = li_r + 4'd1; go_en = 1'b1;
          go_ph = (li_nxt < 4'd4) ? PH_CONF : PH_DEPTHL;
        end
        PH_DEPTHL: begin
          luma_nxt = v[31:0]; go_en = 1'b1; go_ph = PH_DEPTHC;
        end
        PH_DEPTHC: begin
          if (v != {1'b0, luma_r}) begin
            err_nxt = ST_DEPTH; phase_nxt = PH_DONE;
          end else begin
            go_en = 1'b1; go_ph = PH_POC;
          end
        end
        PH_ORDFLAG: begin
          li_nxt = (v != '0) ? 4'd0 : {1'b0, slc_r};
          go_en = 1'b1; go_ph = PH_ORD0;
        end
        PH_ORD2: begin
          li_nxt = li_r + 4'd1; go_en = 1'b1;
          go_ph = (li_nxt <= {1'b0, slc_r}) ? PH_ORD0 : PH_MINCB;
        end
        PH_MINCB: begin
          mbl_nxt = (v > 33'd60) ? 6'd63 : v[5:0] + 6'd3;
          go_en = 1'b1; go_ph = PH_DIFF;
        end
        PH_DIFF: begin
          t = {28'd0, mbl_r} + {1'b0, v};
          if (t > 34'd6) err_nxt = ST_RANGE;
          else mbl_nxt = t[5:0];
          phase_nxt = PH_DONE;
        end
        PH_DONE: phase_nxt = PH_DONE;
        default: begin
          // plain fields that only advance: step to the next phase code, or jump on after SLPROF_B, SEPCOL and POC
          go_en = 1'b1; go_ph = phase_t'(phase_r + 5'd1);
          if (phase_r == PH_SLPROF_B) go_ph = PH_SL_LVLCHK;
          if (phase_r == PH_SEPCOL)   go_ph = PH_WIDTH;
          if (phase_r == PH_POC)      go_ph = PH_ORDFLAG;
        end
      endcase
    end

    if (go_en) begin
      phase_nxt = go_ph;
      acc_nxt   = '0;
      zc_nxt    = '0;
      // reserved bits: two for each absent sub-layer up to eight
      if (go_ph == PH_RESERVED) fbc_nxt = {1'b0, 4'd8 - {1'b0, slc_nxt}, 1'b0};
      else fbc_nxt = field_len(go_ph);
    end

    if (load) begin
      byte_nxt = head_item.data;
      last_nxt = head_item.last;
      bidx_nxt = 3'd7;
      st_nxt   = S_BITS;
      if (bcnt_r < BCW'(MIN_SET_BYTES)) bcnt_nxt = bcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt; bidx_r <= bidx_nxt; last_r <= last_nxt;
    wc_r <= wc_nxt; hc_r <= hc_nxt; stat_r <= stat_nxt; od_r <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; phase_r <= PH_VPS; fbc_r <= field_len(PH_VPS);
      slc_r <= '0; li_r <= '0; flags_r <= '0; zc_r <= '0; acc_r <= '0;
      luma_r <= '0; mbl_r <= '0; prof_r <= '0; lvl_r <= '0; w_r <= '0;
      h_r <= '0; err_r <= '0; bcnt_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; phase_r <= phase_nxt; fbc_r <= fbc_nxt;
      slc_r <= slc_nxt; li_r <= li_nxt; flags_r <= flags_nxt; zc_r <= zc_nxt;
      acc_r <= acc_nxt; luma_r <= luma_nxt; mbl_r <= mbl_nxt; prof_r <= prof_nxt;
      lvl_r <= lvl_nxt; w_r <= w_nxt; h_r <= h_nxt; err_r <= err_nxt;
      bcnt_r <= bcnt_nxt; ov_r <= ov_nxt;
    end
  end

endmodule

// ===== rtl/hsps_checker.sv =====
// Port-level checks for the SPS parser top level, attached by bind.
// Depends on hsps_pkg and the ports of hevc_sps_field_parser_core.
module hsps_checker
  import hsps_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_OK |-> out_tdata[79:3] == '0)
    else $error("error result carries nonzero fields");

  a_zero_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == ST_OK && out_tdata[31:16] == 16'd0
    |-> out_tdata[74:48] == 27'd0)
    else $error("zero width with nonzero CTB count");

endmodule

bind hevc_sps_field_parser_core hsps_checker u_hsps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/hevc_sps_field_parser_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for hevc_sps_field_parser_core: streams SPS payloads
// built bit by bit and checks each result item against a local parser. Needs hsps_pkg.
module hevc_sps_field_parser_core_test;
  import hsps_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 600;

  // Bit-serial SPS parser; keeps one expected result item per finished set.
  class sps_field_tracker;
    int unsigned     nbytes, fbits, nsub, idx, flags, zeros;
    int unsigned     chroma, ctb_log2, prof, lvl, wid, hgt, err;
    longint unsigned acc, luma;
    phase_t          ph;
    logic [79:0]     pending_results[$];
    int              fails;

    function int unsigned flen(phase_t p);
      case (p)
        PH_VPS:                          return 4;
        PH_MAXSUB, PH_PTLA:              return 3;
        PH_NEST, PH_SEPCOL, PH_CONFFLAG,
        PH_ORDFLAG:                      return 1;
        PH_PROFILE:                      return 5;
        PH_SKIP32:                       return 32;
        PH_SKIP48, PH_SLPROF_B:          return 48;
        PH_LEVEL, PH_SLLEVEL:            return 8;
        PH_SLFLAGS:                      return 2;
        PH_SLPROF_A:                     return 40;
        default:                         return 0;
      endcase
    endfunction

    function void clear();
      nbytes = 0; ph = PH_VPS; fbits = flen(PH_VPS); nsub = 0; idx = 0;
      flags = 0; zeros = 0; acc = 0; chroma = 0; luma = 0; ctb_log2 = 0;
      prof = 0; lvl = 0; wid = 0; hgt = 0; err = 0;
    endfunction

    function void abort(int unsigned code);
      err = code;
      ph  = PH_DONE;
    endfunction

    // Enter a phase, resolving the sub-layer loop decisions on the way.
    function void enter(phase_t p);
      forever begin
        if (p == PH_SL_ENTRY) begin
          if (idx >= nsub || idx > 5) begin
            p = PH_SPSID;
            continue;
          end
          if ((flags >> (2 * idx)) & 1) begin
            p = PH_SLPROF_A;
            break;
          end
          p = PH_SL_LVLCHK;
          continue;
        end
        if (p == PH_SL_LVLCHK) begin
          if ((flags >> (2 * idx + 1)) & 1) begin
            p = PH_SLLEVEL;
            break;
          end
          idx++;
          p = PH_SL_ENTRY;
          continue;
        end
        break;
      end
      ph    = p;
      fbits = (p == PH_RESERVED) ? 2 * (8 - nsub) : flen(p);
      acc   = 0;
      zeros = 0;
    endfunction

    function void field_done(longint unsigned v);
      longint unsigned t;
      case (ph)
        PH_VPS:    enter(PH_MAXSUB);
        PH_MAXSUB: begin
          nsub = v & 7;
          if (nsub > 6) abort(ST_SUBLAYERS);
          else enter(PH_NEST);
        end
        PH_NEST:    enter(PH_PTLA);
        PH_PTLA:    enter(PH_PROFILE);
        PH_PROFILE: begin
          prof = v & 31;
          enter(PH_SKIP32);
        end
        PH_SKIP32:  enter(PH_SKIP48);
        PH_SKIP48:  enter(PH_LEVEL);
        PH_LEVEL: begin
          lvl = v & 255;
          idx = 0;
          enter(nsub > 0 ? PH_SLFLAGS : PH_SPSID);
        end
        PH_SLFLAGS: begin
          if (idx < 6)
            flags |= (((v >> 1) & 1) << (2 * idx)) | ((v & 1) << (2 * idx + 1));
          idx++;
          enter(idx < nsub ? PH_SLFLAGS : PH_RESERVED);
        end
        PH_RESERVED: begin
          idx = 0;
          enter(PH_SL_ENTRY);
        end
        PH_SLPROF_A: enter(PH_SLPROF_B);
        PH_SLPROF_B: enter(PH_SL_LVLCHK);
        PH_SLLEVEL: begin
          idx++;
          enter(PH_SL_ENTRY);
        end
        PH_SPSID: begin
          if (v > 15) abort(ST_ID);
          else enter(PH_CHROMA);
        end
        PH_CHROMA: begin
          if (v > 3) abort(ST_CHROMA);
          else begin
            chroma = v;
            enter(v == 3 ? PH_SEPCOL : PH_WIDTH);
          end
        end
        PH_SEPCOL: enter(PH_WIDTH);
        PH_WIDTH: begin
          if (v > 65535) abort(ST_RANGE);
          else begin
            wid = v;
            enter(PH_HEIGHT);
          end
        end
        PH_HEIGHT: begin
          if (v > 65535) abort(ST_RANGE);
          else begin
            hgt = v;
            enter(PH_CONFFLAG);
          end
        end
        PH_CONFFLAG: begin
          idx = 0;
          enter(v != 0 ? PH_CONF : PH_DEPTHL);
        end
        PH_CONF: begin
          idx++;
          enter(idx < 4 ? PH_CONF : PH_DEPTHL);
        end
        PH_DEPTHL: begin
          luma = v & 32'hFFFF_FFFF;
          enter(PH_DEPTHC);
        end
        PH_DEPTHC: begin
          if (v != luma) abort(ST_DEPTH);
          else enter(PH_POC);
        end
        PH_POC:     enter(PH_ORDFLAG);
        PH_ORDFLAG: begin
          idx = (v != 0) ? 0 : nsub;
          enter(PH_ORD0);
        end
        PH_ORD0:    enter(PH_ORD1);
        PH_ORD1:    enter(PH_ORD2);
        PH_ORD2: begin
          idx++;
          enter(idx <= nsub ? PH_ORD0 : PH_MINCB);
        end
        PH_MINCB: begin
          ctb_log2 = (v > 60) ? 63 : v + 3;
          enter(PH_DIFF);
        end
        PH_DIFF: begin
          t = ctb_log2 + v;
          if (t > 6) abort(ST_RANGE);
          else begin
            ctb_log2 = t;
            ph = PH_DONE;
          end
        end
        default: ph = PH_DONE;
      endcase
    endfunction

    function void take_bit(bit b);
      if (err != 0 || ph == PH_DONE) return;
      if (flen(ph) == 0 && ph != PH_RESERVED) begin
        // Exp-Golomb: count the zero prefix, then read as many suffix bits
        if (acc == 0) begin
          if (!b) begin
            zeros++;
            if (zeros >= 32) abort(ST_RANGE);
            return;
          end
          if (zeros == 0) begin
            field_done(0);
            return;
          end
          acc   = 1;
          fbits = zeros;
          return;
        end
        acc = ((acc << 1) | b) & 33'h1_FFFF_FFFF;
        fbits--;
        if (fbits == 0) field_done(acc - 1);
        return;
      end
      acc = ((acc << 1) | b) & 33'h1_FFFF_FFFF;
      if (fbits > 0) fbits--;
      if (fbits == 0) field_done(acc);
    endfunction

    function void note_byte(logic [7:0] data, logic last);
      status_t         st;
      longint unsigned csz, wc, hc;
      int unsigned     sh;
      if (nbytes < 20) nbytes++;
      for (int i = 7; i >= 0; i--) take_bit(data[i]);
      if (!last) return;
      if (nbytes < 20)        st = ST_SHORT;
      else if (err != 0)      st = status_t'(err);
      else if (ph != PH_DONE) st = ST_TRUNC;
      else                    st = ST_OK;
      if (st == ST_OK) begin
        sh  = ctb_log2 & 7;
        csz = 64'd1 << sh;
        wc  = (wid + csz - 1) >> sh;
        hc  = (hgt + csz - 1) >> sh;
        pending_results.push_back({5'd0, 27'(wc * hc), 16'(hgt), 16'(wid), 8'(lvl),
                                   5'(prof), st});
      end else begin
        pending_results.push_back({77'd0, st});
      end
      clear();
    endfunction

    function void check_result(logic [79:0] got);
      logic [79:0] want;
      if (pending_results.size() == 0) begin
        $error("unexpected result item %h", got);
        fails++;
        return;
      end
      want = pending_results.pop_front();
      if (got[2:0] !== want[2:0]) begin
        $error("status: expected %0d got %0d", want[2:0], got[2:0]); fails++;
      end
      if (got[7:3] !== want[7:3]) begin
        $error("profile_idc: expected %0d got %0d", want[7:3], got[7:3]); fails++;
      end
      if (got[15:8] !== want[15:8]) begin
        $error("level_idc: expected %0d got %0d", want[15:8], got[15:8]); fails++;
      end
      if (got[31:16] !== want[31:16]) begin
        $error("pic_width: expected %0d got %0d", want[31:16], got[31:16]); fails++;
      end
      if (got[47:32] !== want[47:32]) begin
        $error("pic_height: expected %0d got %0d", want[47:32], got[47:32]); fails++;
      end
      if (got[74:48] !== want[74:48]) begin
        $error("pic_size_in_ctbs: expected %0d got %0d", want[74:48], got[74:48]);
        fails++;
      end
      if (got[79:75] !== want[79:75]) begin
        $error("padding: expected %0d got %0d", want[79:75], got[79:75]); fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  sps_field_tracker tracker = new();
  int  send_idle_pct, recv_idle_pct;
  int  bytes_sent, sets_done, stall_cycles;
  bit  hold_req, hold_done;
  int  hold_left;
  bit  bits[$];
  logic [7:0] set_bytes[$];

  hevc_sps_field_parser_core uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random back-pressure, plus one long hold-off that lets the
  // byte queue fill so the input stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) tracker.check_result(out_tdata);
  end

  // Watchdog: count cycles with no item moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    tracker.note_byte(data, last);
    bytes_sent++;
  endtask

  task automatic put_bits(input longint unsigned v, input int n);
    for (int i = n - 1; i >= 0; i--) bits.push_back(v[i]);
  endtask

  // Exp-Golomb code of v (v up to 2^32 - 1).
  task automatic put_ue(input longint unsigned v);
    longint unsigned c;
    int n;
    c = v + 1;
    n = 0;
    while ((c >> n) != 0) n++;
    put_bits(0, n - 1);
    put_bits(c, n);
  endtask

  function automatic longint unsigned rand_ue(int maxv);
    case ($urandom_range(9))
      0:       return 0;
      1:       return 64'hFFFF_FFFE;
      2:       return $urandom;
      default: return $urandom_range(maxv);
    endcase
  endfunction

  // Build one parameter set, mostly well formed, with an occasional fault.
  task automatic build_set();
    int fault, nsub, fl[6], mincb, chroma_v;
    longint unsigned dl;
    bits.delete();
    set_bytes.delete();
    fault = ($urandom_range(99) < 40) ? $urandom_range(1, 10) : 0;
    nsub  = (fault == 1) ? 7 : $urandom_range(6);
    put_bits($urandom, 4);
    put_bits(nsub, 3);
    put_bits($urandom, 1);
    put_bits($urandom, 3);
    put_bits($urandom, 5);
    put_bits($urandom, 32);
    put_bits({$urandom, $urandom}, 48);
    put_bits($urandom, 8);
    if (nsub > 0 && nsub < 7) begin
      for (int i = 0; i < nsub; i++) begin
        fl[i] = $urandom_range(3);
        put_bits(fl[i], 2);
      end
      put_bits($urandom, 2 * (8 - nsub));
      for (int i = 0; i < nsub; i++) begin
        if (fl[i][1]) begin
          put_bits({$urandom, $urandom}, 40);
          put_bits({$urandom, $urandom}, 48);
        end
        if (fl[i][0]) put_bits($urandom, 8);
      end
    end
    put_ue(fault == 2 ? $urandom_range(16, 300) : $urandom_range(15));
    if (fault == 3) begin
      put_ue($urandom_range(4, 40));
    end else begin
      chroma_v = ($urandom_range(3) == 3) ? 3 : $urandom_range(3);
      put_ue(chroma_v);
      // a chroma format of 3 adds the separate colour plane flag
      if (chroma_v == 3) put_bits($urandom, 1);
    end
    if (fault == 4) put_ue($urandom_range(65536, 200000));
    else if ($urandom_range(9) == 0) put_ue($urandom_range(1) ? 65535 : 0);
    else put_ue($urandom_range(1, 4096));
    if (fault == 5) put_ue(64'hFFFF_FFFF);
    else put_ue($urandom_range(1, 2160));
    if ($urandom_range(1)) begin
      put_bits(1, 1);
      repeat (4) put_ue(rand_ue(16));
    end else begin
      put_bits(0, 1);
    end
    dl = rand_ue(8);
    put_ue(dl);
    put_ue(fault == 6 ? dl + $urandom_range(1, 3) : dl);
    put_ue(rand_ue(12));
    if ($urandom_range(1)) begin
      put_bits(1, 1);
      repeat (3 * (nsub + 1)) put_ue(rand_ue(10));
    end else begin
      put_bits(0, 1);
      repeat (3) put_ue(rand_ue(10));
    end
    mincb = $urandom_range(3);
    put_ue(mincb);
    if (fault == 7) put_ue(4 - mincb + $urandom_range(5));
    else put_ue($urandom_range(3 - mincb));
    if (fault == 8) put_bits(0, 32);
    while (bits.size() % 8 != 0) bits.push_back(1'($urandom_range(1)));
    for (int i = 0; i < bits.size(); i += 8)
      set_bytes.push_back({bits[i], bits[i+1], bits[i+2], bits[i+3],
                           bits[i+4], bits[i+5], bits[i+6], bits[i+7]});
    repeat ($urandom_range(3)) set_bytes.push_back(8'($urandom));
    while (set_bytes.size() < 20) set_bytes.push_back(8'($urandom));
    if (fault == 9) set_bytes = set_bytes[0:$urandom_range(20, set_bytes.size() - 1)];
    if (fault == 10) set_bytes = set_bytes[0:$urandom_range(18)];
  endtask

  task automatic send_set();
    foreach (set_bytes[i]) send_byte(set_bytes[i], i == set_bytes.size() - 1);
    sets_done++;
  endtask

  initial begin
    send_idle_pct = 18;
    recv_idle_pct = 85;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one-byte sets at both data extremes, then a twenty-byte set of
    // all ones that codes seven sub-layers.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    repeat (19) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    while (bytes_sent < 1550 || sets_done < 40) begin
      if (bytes_sent >= 500 && bytes_sent < 1000) begin
        send_idle_pct = 85;
        recv_idle_pct = 18;
        hold_req = 1'b1;
      end else if (bytes_sent >= 1000) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(9) == 0) begin
        // noise: random bytes of random length
        set_bytes.delete();
        repeat ($urandom_range(1, 40)) set_bytes.push_back(8'($urandom));
      end else begin
        build_set();
      end
      send_set();
    end
    in_tvalid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
